### rtl/ecvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecvm_pkg: shared types and constants for the camera view-matrix block
// Command and multiply-accumulate structs, function codes, stream widths.
// ----------------------------------------------------------------------------
package ecvm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int FUNC_W     = 2;
    localparam int VEC_W      = 32;
    localparam int ANG_W      = 14;
    localparam int ELEM_W     = 34;
    localparam int COL_W      = 2;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 136;
    localparam int MAC_A_W    = 18;
    localparam int TAG_W      = 4;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_SET_POS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_POS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_ANG = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ADD_ANG = 2'd3;

    localparam logic [COL_W-1:0]         LAST_COLUMN = 2'd3;
    localparam logic signed [ELEM_W-1:0] ONE_Q16     = 34'sd65536;

    // accumulate control of one multiplier operation
    localparam logic [1:0] MAC_SINGLE = 2'd0;
    localparam logic [1:0] MAC_START  = 2'd1;
    localparam logic [1:0] MAC_MID    = 2'd2;
    localparam logic [1:0] MAC_END    = 2'd3;

    typedef struct packed {
        logic                    is_angle;
        logic                    is_add;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
    } t_cmd;

    typedef struct packed {
        logic                      valid;
        logic [1:0]                kind;
        logic [TAG_W-1:0]          tag;
        logic signed [MAC_A_W-1:0] a;
        logic signed [VEC_W-1:0]   b;
    } t_mac_op;

    typedef struct packed {
        logic                     valid;
        logic [TAG_W-1:0]         tag;
        logic signed [ELEM_W-1:0] value;
    } t_mac_res;

endpackage

### rtl/euler_camera_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_camera_view_matrix: first-person camera look-at view matrix
// Keeps position and pitch/yaw, applies one command per input beat and
// returns the column-major 4x4 view matrix as four column beats.
// ----------------------------------------------------------------------------
//   channel   dir  beat contents
//   s_axis    in   tuser func, tdata x, y, z, pitch, yaw
//   m_axis    out  tuser column, tdata elem0..elem3, tlast on column 3
//
// from queue pop to its last column beat an item goes through the update in
// ST_IDLE, the table lookups in ST_LOOK0..ST_LOOK2, the products OP_F0..OP_F_P2
// through the single shared 18x32 multiplier, the drain in ST_DRAIN and the column beats.
// the input queue keeps taking beats while a matrix is being computed or sent.
// reset is synchronous, active low; it loads position zero, pitch zero, yaw 270
// degrees and empties the queue.
// a stall on m_axis holds the current column; s_axis tready drops when the
// queue is full.
module euler_camera_view_matrix #(
    parameter int QUEUE_DEPTH = ecvm_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64], pitch_in [109:96],
    // yaw_in [123:110], zero fill [127:124]
    input  logic [ecvm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func [1:0]
    input  logic [ecvm_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // elem0 [33:0], elem1 [67:34], elem2 [101:68], elem3 [135:102]
    output logic [ecvm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // column [1:0]
    output logic [ecvm_pkg::COL_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic               head_valid;
    ecvm_pkg::t_cmd     head;
    logic               pop;
    ecvm_pkg::t_mac_op  mac_op;
    ecvm_pkg::t_mac_res mac_res;

    ecvm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_user       (s_axis_tuser),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    ecvm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_res   (mac_res)
    );

    ecvm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_mac_op     (mac_op),
        .i_mac_res    (mac_res),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_user       (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

endmodule

### rtl/ecvm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecvm_front: input side of the camera view-matrix block
// Takes input beats, decodes the function code and queues the commands.
// ----------------------------------------------------------------------------
module ecvm_front #(
    parameter int DEPTH = ecvm_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ecvm_pkg::IN_DATA_W-1:0] i_data,
    input  logic [ecvm_pkg::FUNC_W-1:0]    i_user,
    output logic                           o_head_valid,
    output ecvm_pkg::t_cmd                 o_head,
    input  logic                           i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ecvm_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    ecvm_pkg::t_cmd   cmd;
    logic             push;

    always_comb begin
        cmd.vec_x = $signed(i_data[31:0]);
        cmd.vec_y = $signed(i_data[63:32]);
        cmd.vec_z = $signed(i_data[95:64]);
        cmd.pitch = $signed(i_data[109:96]);
        cmd.yaw   = $signed(i_data[123:110]);
        case (i_user)
            ecvm_pkg::FUNC_SET_POS: begin
                cmd.is_angle = 1'b0;
                cmd.is_add   = 1'b0;
            end
            ecvm_pkg::FUNC_ADD_POS: begin
                cmd.is_angle = 1'b0;
                cmd.is_add   = 1'b1;
            end
            ecvm_pkg::FUNC_SET_ANG: begin
                cmd.is_angle = 1'b1;
                cmd.is_add   = 1'b0;
            end
            ecvm_pkg::FUNC_ADD_ANG: begin
                cmd.is_angle = 1'b1;
                cmd.is_add   = 1'b1;
            end
            default: begin
                cmd.is_angle = 1'b0;
                cmd.is_add   = 1'b0;
            end
        endcase
    end

    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

endmodule

### rtl/ecvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecvm_mac: shared multiply-accumulate unit
// One 18x32 signed product per cycle, registered, then summed and rounded.
// ----------------------------------------------------------------------------
module ecvm_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecvm_pkg::t_mac_op  i_op,
    output ecvm_pkg::t_mac_res o_res
);

    localparam int PROD_W = ecvm_pkg::MAC_A_W + ecvm_pkg::VEC_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    logic                            r_p_valid;
    logic [1:0]                      r_p_kind;
    logic [ecvm_pkg::TAG_W-1:0]      r_p_tag;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]         sum_base;
    logic signed [ACC_W-1:0]         n_sum;
    logic                            r_res_valid;
    logic [ecvm_pkg::TAG_W-1:0]      r_res_tag;
    logic signed [ecvm_pkg::ELEM_W-1:0] r_res_value;

    // a fresh sum starts from one half so the final shift rounds to nearest
    always_comb begin
        sum_base = (r_p_kind inside {ecvm_pkg::MAC_SINGLE, ecvm_pkg::MAC_START})
                   ? ROUND_HALF : r_acc;
        n_sum    = sum_base + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_p_valid   <= i_op.valid;
            r_res_valid <= r_p_valid
                           && (r_p_kind inside {ecvm_pkg::MAC_SINGLE, ecvm_pkg::MAC_END});
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_kind <= i_op.kind;
        r_p_tag  <= i_op.tag;
        r_prod   <= PROD_W'($signed(i_op.a)) * PROD_W'($signed(i_op.b));
        if (r_p_valid) begin
            r_acc <= n_sum;
        end
        r_res_tag   <= r_p_tag;
        r_res_value <= $signed(n_sum[ecvm_pkg::ELEM_W+15:16]);
    end

    assign o_res.valid = r_res_valid;
    assign o_res.tag   = r_res_tag;
    assign o_res.value = r_res_value;

endmodule

### rtl/ecvm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecvm_back: camera state and matrix sequencer
// Applies one queued command, looks up sines, drives the shared multiplier
// and sends the four matrix columns.
// ----------------------------------------------------------------------------
module ecvm_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  ecvm_pkg::t_cmd                  i_head,
    output logic                            o_pop,
    output ecvm_pkg::t_mac_op               o_mac_op,
    input  ecvm_pkg::t_mac_res              i_mac_res,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ecvm_pkg::OUT_DATA_W-1:0] o_data,
    output logic [ecvm_pkg::COL_W-1:0]      o_user,
    output logic                            o_last
);

    localparam int AW = ecvm_pkg::MAC_A_W;
    localparam int VW = ecvm_pkg::VEC_W;
    localparam int EW = ecvm_pkg::ELEM_W;
    localparam int TW = ecvm_pkg::TAG_W;

    localparam int QUARTER = 1440;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK0 = 3'd1;
    localparam logic [2:0] ST_LOOK1 = 3'd2;
    localparam logic [2:0] ST_LOOK2 = 3'd3;
    localparam logic [2:0] ST_MAC   = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // multiplier operation tags
    localparam logic [TW-1:0] OP_F0   = 4'd0;
    localparam logic [TW-1:0] OP_F2   = 4'd1;
    localparam logic [TW-1:0] OP_U0   = 4'd2;
    localparam logic [TW-1:0] OP_U2   = 4'd3;
    localparam logic [TW-1:0] OP_S_P0 = 4'd4;
    localparam logic [TW-1:0] OP_S_P2 = 4'd5;
    localparam logic [TW-1:0] OP_U_P0 = 4'd6;
    localparam logic [TW-1:0] OP_U_P1 = 4'd7;
    localparam logic [TW-1:0] OP_U_P2 = 4'd8;
    localparam logic [TW-1:0] OP_F_P0 = 4'd9;
    localparam logic [TW-1:0] OP_F_P1 = 4'd10;
    localparam logic [TW-1:0] OP_F_P2 = 4'd11;

    localparam logic [ecvm_pkg::COL_W-1:0] COL_ROT_X = 2'd0;
    localparam logic [ecvm_pkg::COL_W-1:0] COL_ROT_Y = 2'd1;
    localparam logic [ecvm_pkg::COL_W-1:0] COL_ROT_Z = 2'd2;

    localparam logic signed [14:0] PITCH_MAX = 15'sd1424;
    localparam logic signed [14:0] PITCH_MIN = -15'sd1424;
    localparam logic signed [15:0] FULL_TURN = 16'sd5760;
    localparam logic signed [15:0] TWO_TURNS = 16'sd11520;
    localparam logic [12:0]        YAW_RESET = 13'd4320;
    localparam logic [63:0]        PI_Q30    = 64'd3373259426;

    typedef logic [16:0] t_sine_rom [0:QUARTER];

    typedef struct packed {
        logic        neg;
        logic [10:0] idx;
    } t_fold;

    // quarter-wave sine in Q16.16 from an exact Q30 series, built at elaboration
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'(k) * PI_Q30 + 64'd1440) / 64'd2880;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd8192) >>> 14;
            if (r > 64'sd65536) begin
                r = 64'sd65536;
            end
            rom[k] = r[16:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    function automatic logic signed [11:0] clamp_pitch(input logic signed [14:0] v);
        logic signed [14:0] t;
        t = v;
        if (t > PITCH_MAX) begin
            t = PITCH_MAX;
        end else if (t < PITCH_MIN) begin
            t = PITCH_MIN;
        end
        return t[11:0];
    endfunction

    function automatic logic [12:0] wrap_yaw(input logic signed [14:0] v);
        logic signed [15:0] t;
        t = 16'(v);
        if (t < 0) begin
            t = t + FULL_TURN;
            if (t < 0) begin
                t = t + FULL_TURN;
            end
        end else if (t >= TWO_TURNS) begin
            t = t - TWO_TURNS;
        end else if (t >= FULL_TURN) begin
            t = t - FULL_TURN;
        end
        return t[12:0];
    endfunction

    // quadrant fold of an angle in 0..5759 onto the quarter table
    function automatic t_fold fold_angle(input logic [12:0] a);
        t_fold       f;
        logic [12:0] r;
        if (a < 13'd1440) begin
            r     = a;
            f.neg = 1'b0;
            f.idx = r[10:0];
        end else if (a < 13'd2880) begin
            r     = 13'd2880 - a;
            f.neg = 1'b0;
            f.idx = r[10:0];
        end else if (a < 13'd4320) begin
            r     = a - 13'd2880;
            f.neg = 1'b1;
            f.idx = r[10:0];
        end else begin
            r     = 13'd5760 - a;
            f.neg = 1'b1;
            f.idx = r[10:0];
        end
        return f;
    endfunction

    logic [2:0]                    r_state;
    logic signed [VW-1:0]          r_pos [3];
    logic signed [11:0]            r_pitch;
    logic [12:0]                   r_yaw;
    logic [TW-1:0]                 r_step;
    logic [ecvm_pkg::COL_W-1:0]    r_col;

    logic signed [VW-1:0]          n_pos [3];
    logic signed [11:0]            n_pitch;
    logic [12:0]                   n_yaw;
    logic signed [VW-1:0]          vec [3];
    logic signed [VW:0]            pos_sum;
    logic signed [14:0]            pitch_sum;
    logic signed [14:0]            yaw_sum;

    logic signed [13:0]            pitch_wide;
    logic [12:0]                   pitch_ang;
    logic [12:0]                   look_ang;
    logic [12:0]                   cos_ang;
    t_fold                         fold_sin;
    t_fold                         fold_cos;
    logic [16:0]                   r_rom_sin;
    logic [16:0]                   r_rom_cos;
    logic                          r_neg_sin;
    logic                          r_neg_cos;
    logic signed [AW-1:0]          sin_val;
    logic signed [AW-1:0]          cos_val;

    logic signed [AW-1:0]          r_sp;
    logic signed [AW-1:0]          r_cp;
    logic signed [AW-1:0]          r_sy;
    logic signed [AW-1:0]          r_cy;
    logic signed [AW-1:0]          r_f0;
    logic signed [AW-1:0]          r_f2;
    logic signed [AW-1:0]          r_u0;
    logic signed [AW-1:0]          r_u2;
    logic signed [EW-1:0]          r_dot_s;
    logic signed [EW-1:0]          r_dot_u;
    logic signed [EW-1:0]          r_dot_f;

    logic signed [AW-1:0]          neg_sy;
    logic signed [AW-1:0]          neg_cy;
    logic signed [AW-1:0]          neg_sp;
    logic signed [AW-1:0]          neg_f0;
    logic signed [AW-1:0]          neg_f2;
    logic signed [EW-1:0]          elem [4];
    logic                          emit_done;

    // ---------------- state update of the popped command ----------------
    assign o_pop = (r_state == ST_IDLE) && i_head_valid;

    always_comb begin
        vec[0]    = i_head.vec_x;
        vec[1]    = i_head.vec_y;
        vec[2]    = i_head.vec_z;
        n_pos     = r_pos;
        n_pitch   = r_pitch;
        n_yaw     = r_yaw;
        pos_sum   = '0;
        pitch_sum = 15'($signed(i_head.pitch))
                    + (i_head.is_add ? 15'($signed(r_pitch)) : 15'sd0);
        yaw_sum   = 15'($signed(i_head.yaw))
                    + (i_head.is_add ? $signed({2'b00, r_yaw}) : 15'sd0);
        if (i_head.is_angle) begin
            n_pitch = clamp_pitch(pitch_sum);
            n_yaw   = wrap_yaw(yaw_sum);
        end else begin
            for (int i = 0; i < 3; i++) begin
                pos_sum = (VW + 1)'(r_pos[i]) + (VW + 1)'(vec[i]);
                if (!i_head.is_add) begin
                    n_pos[i] = vec[i];
                end else if (pos_sum[VW] != pos_sum[VW-1]) begin
                    // saturate on signed overflow
                    n_pos[i] = pos_sum[VW] ? {1'b1, {(VW - 1){1'b0}}}
                                           : {1'b0, {(VW - 1){1'b1}}};
                end else begin
                    n_pos[i] = pos_sum[VW-1:0];
                end
            end
        end
    end

    // ---------------- sine lookups, two table ports ----------------
    always_comb begin
        pitch_wide = 14'(r_pitch);
        pitch_ang  = pitch_wide[13] ? 13'(pitch_wide + 14'sd5760) : 13'(pitch_wide);
        look_ang   = (r_state == ST_LOOK1) ? r_yaw : pitch_ang;
        cos_ang    = look_ang + 13'd1440;
        if (cos_ang >= 13'd5760) begin
            cos_ang = cos_ang - 13'd5760;
        end
        fold_sin = fold_angle(look_ang);
        fold_cos = fold_angle(cos_ang);
        sin_val  = r_neg_sin ? -$signed({1'b0, r_rom_sin}) : $signed({1'b0, r_rom_sin});
        cos_val  = r_neg_cos ? -$signed({1'b0, r_rom_cos}) : $signed({1'b0, r_rom_cos});
    end

    always_ff @(posedge i_clk) begin
        r_rom_sin <= SINE_ROM[fold_sin.idx];
        r_rom_cos <= SINE_ROM[fold_cos.idx];
        r_neg_sin <= fold_sin.neg;
        r_neg_cos <= fold_cos.neg;
    end

    // ---------------- multiplier schedule ----------------
    always_comb begin
        neg_sy = -r_sy;
        neg_cy = -r_cy;
        neg_sp = -r_sp;
        neg_f0 = -r_f0;
        neg_f2 = -r_f2;

        o_mac_op.valid = (r_state == ST_MAC);
        o_mac_op.tag   = r_step;
        o_mac_op.kind  = ecvm_pkg::MAC_SINGLE;
        o_mac_op.a     = '0;
        o_mac_op.b     = '0;
        case (r_step)
            OP_F0: begin
                o_mac_op.a = r_cy;
                o_mac_op.b = VW'(r_cp);
            end
            OP_F2: begin
                o_mac_op.a = r_sy;
                o_mac_op.b = VW'(r_cp);
            end
            OP_U0: begin
                o_mac_op.a = neg_cy;
                o_mac_op.b = VW'(r_sp);
            end
            OP_U2: begin
                o_mac_op.a = neg_sy;
                o_mac_op.b = VW'(r_sp);
            end
            OP_S_P0: begin
                o_mac_op.kind = ecvm_pkg::MAC_START;
                o_mac_op.a    = neg_sy;
                o_mac_op.b    = r_pos[0];
            end
            OP_S_P2: begin
                o_mac_op.kind = ecvm_pkg::MAC_END;
                o_mac_op.a    = r_cy;
                o_mac_op.b    = r_pos[2];
            end
            OP_U_P0: begin
                o_mac_op.kind = ecvm_pkg::MAC_START;
                o_mac_op.a    = r_u0;
                o_mac_op.b    = r_pos[0];
            end
            OP_U_P1: begin
                o_mac_op.kind = ecvm_pkg::MAC_MID;
                o_mac_op.a    = r_cp;
                o_mac_op.b    = r_pos[1];
            end
            OP_U_P2: begin
                o_mac_op.kind = ecvm_pkg::MAC_END;
                o_mac_op.a    = r_u2;
                o_mac_op.b    = r_pos[2];
            end
            OP_F_P0: begin
                o_mac_op.kind = ecvm_pkg::MAC_START;
                o_mac_op.a    = r_f0;
                o_mac_op.b    = r_pos[0];
            end
            OP_F_P1: begin
                o_mac_op.kind = ecvm_pkg::MAC_MID;
                o_mac_op.a    = r_sp;
                o_mac_op.b    = r_pos[1];
            end
            OP_F_P2: begin
                o_mac_op.kind = ecvm_pkg::MAC_END;
                o_mac_op.a    = r_f2;
                o_mac_op.b    = r_pos[2];
            end
            default: begin
                o_mac_op.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK1) begin
            r_sp <= sin_val;
            r_cp <= cos_val;
        end
        if (r_state == ST_LOOK2) begin
            r_sy <= sin_val;
            r_cy <= cos_val;
        end
        if (i_mac_res.valid) begin
            case (i_mac_res.tag)
                OP_F0:   r_f0    <= i_mac_res.value[AW-1:0];
                OP_F2:   r_f2    <= i_mac_res.value[AW-1:0];
                OP_U0:   r_u0    <= i_mac_res.value[AW-1:0];
                OP_U2:   r_u2    <= i_mac_res.value[AW-1:0];
                OP_S_P2: r_dot_s <= i_mac_res.value;
                OP_U_P2: r_dot_u <= i_mac_res.value;
                OP_F_P2: r_dot_f <= i_mac_res.value;
                default: ;
            endcase
        end
    end

    // ---------------- column beats ----------------
    always_comb begin
        elem[3] = '0;
        case (r_col)
            COL_ROT_X: begin
                elem[0] = EW'(neg_sy);
                elem[1] = EW'(r_u0);
                elem[2] = EW'(neg_f0);
            end
            COL_ROT_Y: begin
                elem[0] = '0;
                elem[1] = EW'(r_cp);
                elem[2] = EW'(neg_sp);
            end
            COL_ROT_Z: begin
                elem[0] = EW'(r_cy);
                elem[1] = EW'(r_u2);
                elem[2] = EW'(neg_f2);
            end
            default: begin
                elem[0] = -r_dot_s;
                elem[1] = -r_dot_u;
                elem[2] = r_dot_f;
                elem[3] = ecvm_pkg::ONE_Q16;
            end
        endcase
    end

    assign o_valid   = (r_state == ST_EMIT);
    assign o_data    = {elem[3], elem[2], elem[1], elem[0]};
    assign o_user    = r_col;
    assign o_last    = (r_col == ecvm_pkg::LAST_COLUMN);
    assign emit_done = o_valid && i_ready && o_last;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '{default: '0};
            r_pitch <= '0;
            r_yaw   <= YAW_RESET;
            r_step  <= '0;
            r_col   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head_valid) begin
                        r_pos   <= n_pos;
                        r_pitch <= n_pitch;
                        r_yaw   <= n_yaw;
                        r_state <= ST_LOOK0;
                    end
                end
                ST_LOOK0: r_state <= ST_LOOK1;
                ST_LOOK1: r_state <= ST_LOOK2;
                ST_LOOK2: begin
                    r_step  <= OP_F0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    if (r_step == OP_F_P2) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    // last dot product lands in its register on this edge
                    if (i_mac_res.valid && i_mac_res.tag == OP_F_P2) begin
                        r_col   <= COL_ROT_X;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_done) begin
                        r_state <= ST_IDLE;
                    end else if (o_valid && i_ready) begin
                        r_col <= r_col + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/ecvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecvm_checker: port-level checks for the camera view-matrix block
// Watches the result stream for column order, framing and the fixed row.
// ----------------------------------------------------------------------------
module ecvm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ecvm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ecvm_pkg::COL_W-1:0]      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // tlast marks exactly the translation column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == ecvm_pkg::LAST_COLUMN)))
        else $error("tlast does not match column");

    // bottom row is 0 0 0 1.0
    a_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == ecvm_pkg::LAST_COLUMN)
                ? (m_axis_tdata[135:102] == ecvm_pkg::ONE_Q16)
                : (m_axis_tdata[135:102] == '0)))
        else $error("wrong bottom row entry");

    // columns of one matrix follow each other without a gap
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 1'b1))
        else $error("column sequence broken");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind euler_camera_view_matrix ecvm_checker u_checker (.*);
